// File: hw/rtl/assert_macros.svh
// Assertion macros of the digest engine, included by its core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold whenever the antecedent is seen (same cycle).
`define HS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Property whose consequent must hold in the cycle after the antecedent.
`define HS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
// Condition that must never be seen.
`define HS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");
`else
`define HS_ASSERT_IMPL(lbl, ante, cons)
`define HS_ASSERT_NEXT(lbl, ante, cons)
`define HS_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/hs_pkg.sv
// Types, constants and round functions of the SHA-256 / HMAC digest engine.
package hs_pkg;

  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_MSG = 2'd1,
    OP_FIN = 2'd2,
    OP_NOP = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [6:0] LEN_POS   = 7'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: hw/rtl/hmac_sha256_engine_core.sv
// A message byte, or a key byte after the 65th, is absorbed into the block register; a byte that
// fills the block starts the round unit. A short key byte is only stored. The 65th key byte
// hashes the stored key, then itself. Finish pads the message. In keyed mode the first message item
// first completes a long key's digest with a padding pass, then aligns the key and absorbs the inner
// key block; keyed finish adds the outer pass. The shared round unit runs one round per cycle.
// Words leave one per cycle as the sink takes them; async reset clears state, key and mode.
module hmac_sha256_engine_core import hs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  // The sequencer feeds one byte per cycle into the block register. Every source of bytes
  // (key dump, pads, message, padding, inner digest) is a state of its own; when a byte
  // fills the block the round unit is started and the sequencer waits in S_COMP.
  typedef enum logic [3:0] {
    S_IDLE, S_PEND, S_KEYDUMP, S_KLOAD, S_NORM, S_IPAD, S_P80, S_PZ,
    S_PLEN, S_PDONE, S_OPAD, S_INNERB, S_COMP, S_OUT
  } state_e;

  // What a padding pass finishes: the long-key digest, the inner or the final hash.
  typedef enum logic [1:0] {PK_KEY, PK_INNER, PK_FINAL} pad_kind_e;

  typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_PLAIN, PH_HMAC} phase_e;

  state_e       state_q, ret_q, abs_nxt;
  pad_kind_e    pk_q;
  phase_e       phase_q;
  logic         mode_q;
  hash_t        h_q, rnd_v;
  logic [63:0]  bitc_q, len_q;
  logic [511:0] blk_q, blk_d;
  logic [6:0]   fill_q;
  logic [511:0] key_q;
  logic [6:0]   klen_q;
  logic         kh_q;
  logic [7:0]   pend_q;
  logic         fin_q;
  logic [5:0]   cnt_q;
  logic [255:0] dig_q, h_vec;
  logic [2:0]   oidx_q;
  logic         ovalid_q;
  out_t         out_q;
  logic         abs_en, abs_cnt, rnd_start, rnd_done;
  logic [7:0]   abs_byte;
  logic         in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = ovalid_q && out_ready_i;

  // Hash words laid out as digest bytes, first word on top.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_vec[255 - 32*i -: 32] = h_q[i];
    end
  end

  // Byte source of the current state and the state to go to after it.
  always_comb begin
    abs_en   = 1'b0;
    abs_cnt  = 1'b0;
    abs_byte = '0;
    abs_nxt  = state_q;
    unique case (state_q)
      S_PEND: begin
        abs_en   = 1'b1;
        abs_cnt  = 1'b1;
        abs_byte = pend_q;
        abs_nxt  = S_IDLE;
      end
      S_KEYDUMP: begin
        abs_en   = 1'b1;
        abs_cnt  = 1'b1;
        abs_byte = key_q[511:504];
        abs_nxt  = (cnt_q == 6'd63) ? S_PEND : S_KEYDUMP;
      end
      S_IPAD: begin
        abs_en   = 1'b1;
        abs_cnt  = 1'b1;
        abs_byte = key_q[511:504] ^ IPAD_BYTE;
        abs_nxt  = (cnt_q == 6'd63) ? (fin_q ? S_P80 : S_PEND) : S_IPAD;
      end
      S_OPAD: begin
        abs_en   = 1'b1;
        abs_cnt  = 1'b1;
        abs_byte = key_q[511:504] ^ OPAD_BYTE;
        abs_nxt  = (cnt_q == 6'd63) ? S_INNERB : S_OPAD;
      end
      S_INNERB: begin
        abs_en   = 1'b1;
        abs_cnt  = 1'b1;
        abs_byte = dig_q[255:248];
        abs_nxt  = (cnt_q == 6'd31) ? S_P80 : S_INNERB;
      end
      S_P80: begin
        abs_en   = 1'b1;
        abs_byte = PAD_BYTE;
        abs_nxt  = S_PZ;
      end
      S_PZ: begin
        abs_en  = (fill_q != LEN_POS);
        abs_nxt = S_PZ;
      end
      S_PLEN: begin
        abs_en   = 1'b1;
        abs_byte = len_q[63:56];
        abs_nxt  = (cnt_q == 6'd7) ? S_PDONE : S_PLEN;
      end
      default: begin
        abs_en = 1'b0;
      end
    endcase
  end

  assign blk_d     = {blk_q[503:0], abs_byte};
  assign rnd_start = abs_en && (fill_q == 7'd63);

  hs_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rnd_start),
    .block_i (blk_d),
    .hash_i  (h_q),
    .state_o (rnd_v),
    .done_o  (rnd_done)
  );

  always_ff @(posedge clk_i) begin
    if (abs_en) begin
      blk_q <= blk_d;
    end
  end

  // Sequencer, hash state, key store and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      pk_q     <= PK_FINAL;
      phase_q  <= PH_IDLE;
      mode_q   <= 1'b0;
      h_q      <= SHA_IV;
      bitc_q   <= '0;
      len_q    <= '0;
      fill_q   <= '0;
      key_q    <= '0;
      klen_q   <= '0;
      kh_q     <= 1'b0;
      pend_q   <= '0;
      fin_q    <= 1'b0;
      cnt_q    <= '0;
      dig_q    <= '0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        mode_q <= pwdata[0];
      end

      if (abs_en) begin
        if (abs_cnt) begin
          bitc_q <= bitc_q + 64'd8;
        end
        cnt_q <= cnt_q + 6'd1;
        if (rnd_start) begin
          fill_q  <= '0;
          ret_q   <= abs_nxt;
          state_q <= S_COMP;
        end else begin
          fill_q  <= fill_q + 7'd1;
          state_q <= abs_nxt;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            pend_q <= in_data_i.data_byte;
            fin_q  <= (in_data_i.opcode == OP_FIN);
            case (in_data_i.opcode)
              OP_KEY: begin
                // Key bytes count only in HMAC mode and before any message byte.
                if (mode_q && (phase_q == PH_IDLE || phase_q == PH_KEY)) begin
                  phase_q <= PH_KEY;
                  if (kh_q) begin
                    state_q <= S_PEND;
                  end else if (!klen_q[6]) begin
                    key_q  <= {key_q[503:0], in_data_i.data_byte};
                    klen_q <= klen_q + 7'd1;
                  end else begin
                    // Long key: hash the stored 64 bytes, then this one.
                    h_q     <= SHA_IV;
                    bitc_q  <= '0;
                    fill_q  <= '0;
                    cnt_q   <= '0;
                    state_q <= S_KEYDUMP;
                  end
                end
              end
              OP_MSG, OP_FIN: begin
                if (phase_q == PH_IDLE || phase_q == PH_KEY) begin
                  if (mode_q) begin
                    phase_q <= PH_HMAC;
                    if (kh_q) begin
                      pk_q    <= PK_KEY;
                      state_q <= S_P80;
                    end else begin
                      state_q <= S_NORM;
                    end
                  end else begin
                    phase_q <= PH_PLAIN;
                    h_q     <= SHA_IV;
                    bitc_q  <= '0;
                    fill_q  <= '0;
                    pk_q    <= PK_FINAL;
                    state_q <= (in_data_i.opcode == OP_FIN) ? S_P80 : S_PEND;
                  end
                end else begin
                  pk_q    <= (phase_q == PH_HMAC) ? PK_INNER : PK_FINAL;
                  state_q <= (in_data_i.opcode == OP_FIN) ? S_P80 : S_PEND;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_KEYDUMP: begin
          key_q <= {key_q[503:0], key_q[511:504]};
          if (cnt_q == 6'd63) begin
            kh_q <= 1'b1;
          end
        end
        S_KLOAD: begin
          // Key digest, zero padded, replaces the key.
          key_q   <= {h_vec, 256'd0};
          klen_q  <= 7'd64;
          kh_q    <= 1'b0;
          state_q <= S_NORM;
        end
        S_NORM: begin
          // Move a short key up so that its first byte sits on top.
          if (klen_q[6]) begin
            h_q     <= SHA_IV;
            bitc_q  <= '0;
            fill_q  <= '0;
            cnt_q   <= '0;
            pk_q    <= PK_INNER;
            state_q <= S_IPAD;
          end else begin
            key_q  <= {key_q[503:0], 8'd0};
            klen_q <= klen_q + 7'd1;
          end
        end
        S_IPAD, S_OPAD: begin
          key_q <= {key_q[503:0], key_q[511:504]};
          if (state_q == S_OPAD && cnt_q == 6'd63) begin
            pk_q <= PK_FINAL;
          end
        end
        S_INNERB: begin
          dig_q <= {dig_q[247:0], 8'd0};
        end
        S_P80: begin
          len_q <= bitc_q;
        end
        S_PZ: begin
          if (!abs_en) begin
            cnt_q   <= '0;
            state_q <= S_PLEN;
          end
        end
        S_PLEN: begin
          len_q <= {len_q[55:0], 8'd0};
        end
        S_PDONE: begin
          case (pk_q)
            PK_KEY: begin
              state_q <= S_KLOAD;
            end
            PK_INNER: begin
              dig_q   <= h_vec;
              h_q     <= SHA_IV;
              bitc_q  <= '0;
              fill_q  <= '0;
              cnt_q   <= '0;
              state_q <= S_OPAD;
            end
            default: begin
              oidx_q   <= '0;
              ovalid_q <= 1'b1;
              out_q    <= '{digest_word: h_q[0], word_index: 3'd0, last_word: 1'b0};
              state_q  <= S_OUT;
            end
          endcase
        end
        S_COMP: begin
          if (rnd_done) begin
            for (int i = 0; i < 8; i++) begin
              h_q[i] <= h_q[i] + rnd_v[i];
            end
            state_q <= ret_q;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            if (oidx_q == 3'd7) begin
              // Digest out: drop the key and start over.
              ovalid_q <= 1'b0;
              key_q    <= '0;
              klen_q   <= '0;
              kh_q     <= 1'b0;
              phase_q  <= PH_IDLE;
              h_q      <= SHA_IV;
              bitc_q   <= '0;
              fill_q   <= '0;
              state_q  <= S_IDLE;
            end else begin
              oidx_q <= oidx_q + 3'd1;
              out_q  <= '{digest_word: h_q[oidx_q + 3'd1],
                          word_index:  oidx_q + 3'd1,
                          last_word:   (oidx_q == 3'd6)};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = paddr[2] ? 32'd0 : {31'd0, mode_q};

  // Input is never taken while a digest is being delivered.
  `HS_ASSERT_NEVER(a_no_overlap, in_ready_o && out_valid_o)
  // The block buffer fill never reaches a whole block.
  `HS_ASSERT_NEVER(a_fill_range, fill_q[6])
  // Transfer of the final word returns the engine to idle.
  `HS_ASSERT_NEXT(a_last_idle, out_fire && out_q.last_word, in_ready_o && !out_valid_o)
  // The round unit finishes only while the sequencer waits on it.
  `HS_ASSERT_IMPL(a_done_comp, rnd_done, state_q == S_COMP)

endmodule

// File: hw/rtl/hs_round.sv
// SHA-256 compression unit: one round per cycle over a rolling message schedule.
module hs_round import hs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [511:0] block_i,
  input  hash_t        hash_i,
  output hash_t        state_o,
  output logic         done_o
);

  hash_t             v_q, v_d;
  logic [15:0][31:0] w_q, w_d;
  logic [5:0]        rnd_q;
  logic              busy_q;
  logic              done_q;
  logic [31:0]       t1, t2, w_new;

  always_comb begin
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + ROUND_K[rnd_q] + w_q[0];
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    v_d[0] = t1 + t2;
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3] + t1;
    v_d[5] = v_q[4];
    v_d[6] = v_q[5];
    v_d[7] = v_q[6];
    w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
    for (int j = 0; j < 15; j++) begin
      w_d[j] = w_q[j+1];
    end
    w_d[15] = w_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= hash_i;
      for (int j = 0; j < 16; j++) begin
        w_q[j] <= block_i[511 - 32*j -: 32];
      end
    end else if (busy_q) begin
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  assign state_o = v_q;
  assign done_o  = done_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for the SHA-256 / HMAC-SHA256 digest engine core.
`timescale 1ns / 100ps

module tb import hs_pkg::*; ();

  // Register map and timing figures of the bench.
  localparam logic [2:0] MODE_ADDR   = 3'd0;
  // Long enough for a long-key digest, the inner and outer passes and the padding blocks.
  localparam int         SETTLE_CYC  = 800;
  localparam int         STALL_LIMIT = 20000;
  localparam int         HOLD_CYC    = 3000;
  localparam int         ITEM_TARGET = 250;

  // Message state of the predictor.
  typedef enum int {PH_IDLE, PH_KEY, PH_PLAIN, PH_HMAC} msg_phase_e;

  // The scoreboard carries its own copy of the engine state, works out the eight
  // digest words on each finish transfer and checks the words that come out.
  class digest_scoreboard;
    bit [31:0]  hv [8];
    bit [63:0]  nbits;
    bit [7:0]   blk [64];
    int         fill;
    bit [7:0]   key [64];
    int         klen;
    bit         key_hashing;
    msg_phase_e ph;
    bit         hmac_on;
    out_t       digest_q [$];
    int         errors;
    int         digests;

    function new();
      for (int i = 0; i < 64; i++) key[i] = '0;
      klen = 0; key_hashing = 0; ph = PH_IDLE; hmac_on = 0;
      errors = 0; digests = 0;
      hash_init();
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void hash_init();
      for (int i = 0; i < 8; i++) hv[i] = SHA_IV[i];
      nbits = '0;
      fill = 0;
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
               (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = hv[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hv[i] += v[i];
    endfunction

    function void absorb(bit [7:0] b);
      blk[fill] = b;
      fill++;
      nbits += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void pad_final();
      int f;
      f = fill;
      blk[f] = 8'h80;
      f++;
      if (f > 56) begin
        for (int i = f; i < 64; i++) blk[i] = '0;
        compress();
        f = 0;
      end
      for (int i = f; i < 56; i++) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[56+i] = nbits[63-8*i -: 8];
      compress();
      fill = 0;
    endfunction

    // A message opens: in keyed mode a long key is reduced to its digest, then the inner pad goes in.
    function void open_message();
      if (hmac_on) begin
        if (key_hashing) begin
          pad_final();
          for (int i = 0; i < 32; i++) key[i] = hv[i/4][31-8*(i%4) -: 8];
          for (int i = 32; i < 64; i++) key[i] = '0;
          key_hashing = 0;
        end
        hash_init();
        for (int i = 0; i < 64; i++) absorb(key[i] ^ 8'h36);
        ph = PH_HMAC;
      end else begin
        hash_init();
        ph = PH_PLAIN;
      end
    endfunction

    function void note_input(in_t it);
      bit [7:0] inner [32];
      case (opcode_e'(it.opcode))
        OP_KEY: begin
          if (hmac_on && ph != PH_PLAIN && ph != PH_HMAC) begin
            ph = PH_KEY;
            if (key_hashing) absorb(it.data_byte);
            else if (klen < 64) begin
              key[klen] = it.data_byte;
              klen++;
            end else begin
              hash_init();
              for (int i = 0; i < 64; i++) absorb(key[i]);
              absorb(it.data_byte);
              key_hashing = 1;
            end
          end
        end
        OP_MSG: begin
          if (ph == PH_IDLE || ph == PH_KEY) open_message();
          absorb(it.data_byte);
        end
        OP_FIN: begin
          if (ph == PH_IDLE || ph == PH_KEY) open_message();
          pad_final();
          if (ph == PH_HMAC) begin
            for (int i = 0; i < 32; i++) inner[i] = hv[i/4][31-8*(i%4) -: 8];
            hash_init();
            for (int i = 0; i < 64; i++) absorb(key[i] ^ 8'h5c);
            for (int i = 0; i < 32; i++) absorb(inner[i]);
            pad_final();
          end
          for (int i = 0; i < 8; i++) digest_q.push_back('{hv[i], 3'(i), i == 7});
          for (int i = 0; i < 64; i++) key[i] = '0;
          klen = 0; key_hashing = 0;
          hash_init();
          ph = PH_IDLE;
          digests++;
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (digest_q.size() == 0) begin
        report($sformatf("digest word %h with none expected", got.digest_word));
        return;
      end
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word)
        report($sformatf("word %0d: got %h, want %h", want.word_index,
                         got.digest_word, want.digest_word));
      if (got.word_index !== want.word_index)
        report($sformatf("index: got %0d, want %0d", got.word_index, want.word_index));
      if (got.last_word !== want.last_word)
        report($sformatf("last flag: got %b, want %b", got.last_word, want.last_word));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  digest_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int sent = 0;
  int mode_writes = 0;

  always #1 clk_i = ~clk_i;

  hmac_sha256_engine_core DUT (.*);

  // Both channels are observed at the clock edge; a transfer is noted before
  // any digest word is checked, although a word never follows its own finish
  // transfer in the same cycle.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // The sink: random back-pressure, plus one long hold-off on request so that the
  // engine has to keep a finished digest and refuse further input meanwhile.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYC;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: the run ends if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: timeout, no transfer for %0d cycles", STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid is lowered
  // only when a gap is inserted, so it never drops between back-to-back items.
  task automatic send_item(opcode_e op, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{opcode: op, data_byte: b};
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Waits for every expected digest word, then lets any trailing work settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.digest_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then the access cycle in which the register is written.
  task automatic set_mode(bit m);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= MODE_ADDR; pwdata <= {31'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.hmac_on = m;
    mode_writes++;
  endtask

  // One randomised digest: optional key, a message with some noise mixed in, and
  // usually a finish. Most keys and messages are short; a few are long enough to
  // force a key digest or a second padding block.
  task automatic send_digest(bit with_fin);
    int key_len, msg_len;
    key_len = ($urandom_range(7) == 0) ? $urandom_range(65, 72) : $urandom_range(0, 5);
    msg_len = ($urandom_range(5) == 0) ? $urandom_range(54, 66) : $urandom_range(0, 8);
    for (int i = 0; i < key_len; i++) send_item(OP_KEY, 8'($urandom));
    for (int i = 0; i < msg_len; i++) begin
      if ($urandom_range(9) == 0)
        send_item($urandom_range(1) ? OP_NOP : OP_KEY, 8'($urandom));
      send_item(OP_MSG, 8'($urandom));
    end
    if (with_fin) send_item(OP_FIN, 8'($urandom));
  endtask

  initial begin
    int start_sent;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, plain mode: empty message, extreme bytes, and items that
    // the engine must ignore (no-op opcode, key byte outside keyed mode).
    send_item(OP_FIN, 8'h00);
    send_item(OP_NOP, 8'hff);
    send_item(OP_KEY, 8'hff);
    send_item(OP_MSG, 8'h00);
    send_item(OP_MSG, 8'hff);
    send_item(OP_FIN, 8'hff);
    drain();

    // Keyed mode: a short key, a key byte inside the message, finish on an empty
    // message after a key, and finish with neither key nor message.
    set_mode(1'b1);
    send_item(OP_KEY, 8'h00);
    send_item(OP_KEY, 8'hff);
    send_item(OP_MSG, 8'h5a);
    send_item(OP_KEY, 8'h11);
    send_item(OP_MSG, 8'ha5);
    send_item(OP_FIN, 8'h00);
    send_item(OP_KEY, 8'h36);
    send_item(OP_FIN, 8'h00);
    send_item(OP_FIN, 8'h00);
    drain();

    // Random part in three stages of flow control; the mode is rewritten at
    // random between digests, only once the engine has gone quiet.
    start_sent = sent;
    for (int stage = 0; stage < 3; stage++) begin
      src_idle_pct = (stage == 0) ? 32 : (stage == 1) ? 65 : 0;
      snk_idle_pct = (stage == 0) ? 65 : (stage == 1) ? 32 : 0;
      if (stage == 2) begin
        // Long sink hold-off while two digests are offered back to back.
        hold_req = 1;
        send_digest(1'b1);
        send_digest(1'b1);
        drain();
      end
      while (sent - start_sent < (stage + 1) * ITEM_TARGET / 3) begin
        // A further finish follows: it closes a message sent without one, else hashes an empty one.
        send_digest($urandom_range(5) != 0);
        send_item(OP_FIN, 8'($urandom));
        drain();
        set_mode($urandom_range(1));
      end
    end
    drain();

    if (sb.digest_q.size() != 0)
      sb.report($sformatf("%0d digest words never arrived", sb.digest_q.size()));
    $display("tb: %0d items sent, %0d digests checked, %0d mode writes", sent,
             sb.digests, mode_writes);
    $display("tb: covered plain and keyed digests, long keys, padding edges and stalls");
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
